FILE: sv/tlv_eeprom_ddr_size_parser_macros.svh
`ifndef TLV_EEPROM_DDR_SIZE_PARSER_MACROS_SVH
`define TLV_EEPROM_DDR_SIZE_PARSER_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define TLVDDR_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define TLVDDR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: sv/tlvddr_pkg.sv
package tlvddr_pkg;

   localparam int EEPROM_BYTES = 256;
   localparam int PART_MAX     = 32;
   localparam int HDR_LEN      = 11;
   localparam int SKU_POS      = 10;
   localparam int SKU_MIN      = 14;

   localparam int DATA_W = 8;
   localparam int CODE_W = 3;
   localparam int STAT_W = 3;

   localparam int LIMIT  = EEPROM_BYTES - HDR_LEN;
   localparam int IDX_W  = $clog2(EEPROM_BYTES);
   localparam int LEN_W  = $clog2(LIMIT + 1);
   localparam int OFS_W  = $clog2(LIMIT + 256);
   localparam int PLEN_W = $clog2(PART_MAX + 1);

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [DATA_W-1:0] TLV_VERSION = 8'h01;
   localparam logic [DATA_W-1:0] TYPE_PART   = 8'h22;

   typedef enum logic [CODE_W-1:0] {
      CODE_8GB = 3'd0,
      CODE_4GB = 3'd1,
      CODE_3GB = 3'd2,
      CODE_2GB = 3'd3,
      CODE_1GB = 3'd4
   } code_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK         = 3'd0,
      ST_READ_ERR   = 3'd1,
      ST_BAD_HEADER = 3'd2,
      ST_NO_PART    = 3'd3,
      ST_NO_SKU     = 3'd4,
      ST_BAD_CODE   = 3'd5,
      ST_STREAM_END = 3'd6
   } status_type;

   typedef struct packed {
      logic [DATA_W-1:0] data_byte;
      logic              read_error;
      logic              first;
      logic              last;
      logic              is_part_type;
      logic              is_zero;
      logic              is_version;
      logic              over_limit;
      logic              over_part;
   } word_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

FILE: sv/tlvddr_if.sv
interface tlvddr_req_if;
   logic                            valid;
   logic                            ready;
   logic [tlvddr_pkg::DATA_W-1:0]   data_byte;
   logic                            read_error;
   logic                            first;
   logic                            last;

   modport source(output valid, data_byte, read_error, first, last, input ready);
   modport sink(input valid, data_byte, read_error, first, last, output ready);
endinterface

interface tlvddr_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [tlvddr_pkg::CODE_W-1:0]   ddr_code;
   logic [tlvddr_pkg::STAT_W-1:0]   status;

   modport source(output valid, ddr_code, status, input ready);
   modport sink(input valid, ddr_code, status, output ready);
endinterface

FILE: sv/tlv_eeprom_ddr_size_parser.sv
// A result is registered on rsp_ch when the parser pops the queued word that settles it.
// Throughput: one word per cycle; the parser retires one each cycle unless rsp_ch stalls.
// A four-entry queue keeps accepting up to four words while a result waits to be taken.
// Reset is synchronous and active high; it empties the queue and returns the parser
// to the header state with no result pending.
`include "tlv_eeprom_ddr_size_parser_macros.svh"

module tlv_eeprom_ddr_size_parser (
   input  logic          clock,
   input  logic          reset,
   tlvddr_req_if.sink    req_ch,
   tlvddr_rsp_if.source  rsp_ch
);

   tlvddr_pkg::q_status_type  q_stat;
   tlvddr_pkg::word_type      push_word;
   tlvddr_pkg::word_type      head_word;
   logic                      push;
   logic                      pop;

   tlvddr_front u_front (
      .req_ch (req_ch),
      .q_stat (q_stat),
      .push   (push),
      .word   (push_word)
   );

   tlvddr_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .word_in  (push_word),
      .pop      (pop),
      .word_out (head_word),
      .q_stat   (q_stat)
   );

   tlvddr_back u_back (
      .clock  (clock),
      .reset  (reset),
      .word   (head_word),
      .q_stat (q_stat),
      .pop    (pop),
      .rsp_ch (rsp_ch)
   );

   `TLVDDR_ASSERT_NOW(a_pop_not_empty, clock, reset, pop, !q_stat.empty, "pop from empty queue")
   `TLVDDR_ASSERT_NOW(a_no_pop_on_stall, clock, reset, rsp_ch.valid && !rsp_ch.ready, !pop, "pop while result stalled")
   `TLVDDR_ASSERT_NOW(a_fallback_code, clock, reset, rsp_ch.valid && rsp_ch.status != tlvddr_pkg::ST_OK, rsp_ch.ddr_code == tlvddr_pkg::CODE_8GB, "failure without 8GB fallback")
   `TLVDDR_ASSERT_NEXT(a_push_fills, clock, reset, push && !pop, !q_stat.empty, "queued word lost")

endmodule

FILE: sv/tlvddr_front.sv
module tlvddr_front (
   tlvddr_req_if.sink                req_ch,
   input  tlvddr_pkg::q_status_type  q_stat,
   output logic                      push,
   output tlvddr_pkg::word_type      word
);

   assign req_ch.ready = !q_stat.full;
   assign push         = req_ch.valid && req_ch.ready;

   always_comb begin
      word.data_byte    = req_ch.data_byte;
      word.read_error   = req_ch.read_error;
      word.first        = req_ch.first;
      word.last         = req_ch.last;
      word.is_part_type = (req_ch.data_byte == tlvddr_pkg::TYPE_PART);
      word.is_zero      = (req_ch.data_byte == '0);
      word.is_version   = (req_ch.data_byte == tlvddr_pkg::TLV_VERSION);
      word.over_limit   = (req_ch.data_byte >
                           tlvddr_pkg::DATA_W'(tlvddr_pkg::LIMIT));
      word.over_part    = (req_ch.data_byte >
                           tlvddr_pkg::DATA_W'(tlvddr_pkg::PART_MAX));
   end

endmodule

FILE: sv/tlvddr_queue.sv
module tlvddr_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  tlvddr_pkg::word_type      word_in,
   input  logic                      pop,
   output tlvddr_pkg::word_type      word_out,
   output tlvddr_pkg::q_status_type  q_stat
);

   tlvddr_pkg::word_type               mem_ff [tlvddr_pkg::QUEUE_DEPTH];
   logic [tlvddr_pkg::QPTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [tlvddr_pkg::QPTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [tlvddr_pkg::QCNT_W-1:0]      count_ff, count_in;

   assign word_out     = mem_ff[rd_ptr_ff];
   assign q_stat.full  = (count_ff == tlvddr_pkg::QCNT_W'(tlvddr_pkg::QUEUE_DEPTH));
   assign q_stat.empty = (count_ff == '0);

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= word_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

FILE: sv/tlvddr_back.sv
module tlvddr_back (
   input  logic                      clock,
   input  logic                      reset,
   input  tlvddr_pkg::word_type      word,
   input  tlvddr_pkg::q_status_type  q_stat,
   output logic                      pop,
   tlvddr_rsp_if.source              rsp_ch
);

   typedef enum logic [2:0] {
      PH_HEADER,
      PH_TYPE,
      PH_LEN_OTHER,
      PH_LEN_PART,
      PH_SKIP,
      PH_PART,
      PH_DONE
   } phase_type;

   localparam logic [7:0] CH_D    = 8'h44;
   localparam logic [7:0] CH_G    = 8'h47;
   localparam logic [7:0] CH_ZERO = 8'h30;
   localparam logic [7:0] CH_ONE  = 8'h31;
   localparam logic [7:0] CH_TWO  = 8'h32;
   localparam logic [7:0] CH_THREE = 8'h33;
   localparam logic [7:0] CH_FOUR = 8'h34;
   localparam logic [7:0] CH_EIGHT = 8'h38;

   localparam int SUM_W = tlvddr_pkg::OFS_W + 1;

   function automatic logic [7:0] magic_byte(input logic [2:0] pos);
      logic [7:0] ch;
      case (pos)
         3'd0:    ch = 8'h54;
         3'd1:    ch = 8'h6C;
         3'd2:    ch = 8'h76;
         3'd3:    ch = 8'h49;
         3'd4:    ch = 8'h6E;
         3'd5:    ch = 8'h66;
         3'd6:    ch = 8'h6F;
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

   phase_type                          phase_ff, phase_in;
   logic [tlvddr_pkg::IDX_W-1:0]       byte_index_ff, byte_index_in;
   logic [tlvddr_pkg::LEN_W-1:0]       total_length_ff, total_length_in;
   logic [tlvddr_pkg::OFS_W-1:0]       record_offset_ff, record_offset_in;
   logic [7:0]                         skip_remaining_ff, skip_remaining_in;
   logic [tlvddr_pkg::PLEN_W-1:0]      part_length_ff, part_length_in;
   logic [tlvddr_pkg::PLEN_W-1:0]      part_count_ff, part_count_in;
   logic [31:0]                        sku_chars_ff, sku_chars_in;
   logic                               header_ok_ff, header_ok_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   tlvddr_pkg::code_type               rsp_code_ff, rsp_code_in;
   tlvddr_pkg::status_type             rsp_status_ff, rsp_status_in;

   logic                               live;
   logic                               settle;
   logic                               do_decode;
   tlvddr_pkg::code_type               res_code;
   tlvddr_pkg::status_type             res_status;
   logic [SUM_W-1:0]                   ofs_sum;
   logic [1:0]                         sku_slot;

   assign pop = !q_stat.empty && (!rsp_valid_ff || rsp_ch.ready);

   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.ddr_code = rsp_code_ff;
   assign rsp_ch.status   = rsp_status_ff;

   always_comb begin
      phase_in          = phase_ff;
      byte_index_in     = byte_index_ff;
      total_length_in   = total_length_ff;
      record_offset_in  = record_offset_ff;
      skip_remaining_in = skip_remaining_ff;
      part_length_in    = part_length_ff;
      part_count_in     = part_count_ff;
      sku_chars_in      = sku_chars_ff;
      header_ok_in      = header_ok_ff;
      live              = 1'b0;
      settle            = 1'b0;
      do_decode         = 1'b0;
      res_code          = tlvddr_pkg::CODE_8GB;
      res_status        = tlvddr_pkg::ST_OK;
      ofs_sum           = '0;
      sku_slot          = '0;

      if (pop) begin
         if (word.first) begin
            phase_in          = PH_HEADER;
            byte_index_in     = '0;
            total_length_in   = '0;
            record_offset_in  = '0;
            skip_remaining_in = '0;
            part_length_in    = '0;
            part_count_in     = '0;
            sku_chars_in      = '0;
            header_ok_in      = 1'b1;
         end
         live = (phase_in != PH_DONE);

         case (phase_in)
            PH_HEADER: begin
               if (word.read_error) begin
                  settle     = 1'b1;
                  res_status = tlvddr_pkg::ST_READ_ERR;
               end else if (byte_index_in < tlvddr_pkg::IDX_W'(8)) begin
                  if (word.data_byte != magic_byte(byte_index_in[2:0])) begin
                     header_ok_in = 1'b0;
                  end
               end else if (byte_index_in == tlvddr_pkg::IDX_W'(8)) begin
                  if (!word.is_version) begin
                     header_ok_in = 1'b0;
                  end
               end else if (byte_index_in == tlvddr_pkg::IDX_W'(9)) begin
                  total_length_in = tlvddr_pkg::LEN_W'(!word.is_zero);
               end else begin
                  if (total_length_in != '0 || word.over_limit) begin
                     total_length_in = tlvddr_pkg::LEN_W'(tlvddr_pkg::LIMIT);
                  end else begin
                     total_length_in = word.data_byte[tlvddr_pkg::LEN_W-1:0];
                  end
                  record_offset_in = '0;
                  if (!header_ok_in) begin
                     settle     = 1'b1;
                     res_status = tlvddr_pkg::ST_BAD_HEADER;
                  end else if (total_length_in < tlvddr_pkg::LEN_W'(2)) begin
                     settle     = 1'b1;
                     res_status = tlvddr_pkg::ST_NO_PART;
                  end else begin
                     phase_in = PH_TYPE;
                  end
               end
            end
            PH_TYPE: begin
               if (word.read_error) begin
                  settle     = 1'b1;
                  res_status = tlvddr_pkg::ST_READ_ERR;
               end else begin
                  phase_in = word.is_part_type ? PH_LEN_PART : PH_LEN_OTHER;
               end
            end
            PH_LEN_OTHER: begin
               if (word.read_error) begin
                  settle     = 1'b1;
                  res_status = tlvddr_pkg::ST_READ_ERR;
               end else begin
                  ofs_sum = SUM_W'(record_offset_in) + SUM_W'(word.data_byte)
                            + SUM_W'(2);
                  record_offset_in = ofs_sum[tlvddr_pkg::OFS_W-1:0];
                  if (ofs_sum + SUM_W'(2) > SUM_W'(total_length_in)) begin
                     settle     = 1'b1;
                     res_status = tlvddr_pkg::ST_NO_PART;
                  end else if (word.is_zero) begin
                     phase_in = PH_TYPE;
                  end else begin
                     skip_remaining_in = word.data_byte;
                     phase_in          = PH_SKIP;
                  end
               end
            end
            PH_SKIP: begin
               skip_remaining_in = skip_remaining_in - 1'b1;
               if (skip_remaining_in == '0) begin
                  phase_in = PH_TYPE;
               end
            end
            PH_LEN_PART: begin
               if (word.read_error) begin
                  settle     = 1'b1;
                  res_status = tlvddr_pkg::ST_READ_ERR;
               end else begin
                  if (word.over_part) begin
                     part_length_in = tlvddr_pkg::PLEN_W'(tlvddr_pkg::PART_MAX);
                  end else begin
                     part_length_in = word.data_byte[tlvddr_pkg::PLEN_W-1:0];
                  end
                  part_count_in = '0;
                  sku_chars_in  = '0;
                  if (word.is_zero) begin
                     do_decode = 1'b1;
                  end else begin
                     phase_in = PH_PART;
                  end
               end
            end
            PH_PART: begin
               if (word.read_error) begin
                  settle     = 1'b1;
                  res_status = tlvddr_pkg::ST_READ_ERR;
               end else begin
                  if (part_count_in >= tlvddr_pkg::PLEN_W'(tlvddr_pkg::SKU_POS) &&
                      part_count_in < tlvddr_pkg::PLEN_W'(tlvddr_pkg::SKU_POS + 4)) begin
                     sku_slot = 2'(part_count_in -
                                   tlvddr_pkg::PLEN_W'(tlvddr_pkg::SKU_POS));
                     sku_chars_in[{~sku_slot, 3'b000} +: 8] = word.data_byte;
                  end
                  part_count_in = part_count_in + 1'b1;
                  if (part_count_in == part_length_in) begin
                     do_decode = 1'b1;
                  end
               end
            end
            default: begin
            end
         endcase

         if (do_decode) begin
            settle = 1'b1;
            if (part_length_in < tlvddr_pkg::PLEN_W'(tlvddr_pkg::SKU_MIN) ||
                sku_chars_in[31:24] != CH_D || sku_chars_in[7:0] != CH_G) begin
               res_status = tlvddr_pkg::ST_NO_SKU;
            end else if (sku_chars_in[23:16] != CH_ZERO) begin
               res_status = tlvddr_pkg::ST_BAD_CODE;
            end else begin
               case (sku_chars_in[15:8])
                  CH_EIGHT: res_code = tlvddr_pkg::CODE_8GB;
                  CH_FOUR:  res_code = tlvddr_pkg::CODE_4GB;
                  CH_THREE: res_code = tlvddr_pkg::CODE_3GB;
                  CH_TWO:   res_code = tlvddr_pkg::CODE_2GB;
                  CH_ONE:   res_code = tlvddr_pkg::CODE_1GB;
                  default:  res_status = tlvddr_pkg::ST_BAD_CODE;
               endcase
            end
         end

         if (live && !settle) begin
            if (word.last ||
                byte_index_in == tlvddr_pkg::IDX_W'(tlvddr_pkg::EEPROM_BYTES - 1)) begin
               settle     = 1'b1;
               res_status = tlvddr_pkg::ST_STREAM_END;
            end
            byte_index_in = byte_index_in + 1'b1;
         end

         if (settle) begin
            phase_in = PH_DONE;
         end
      end

      if (pop && settle) begin
         rsp_valid_in  = 1'b1;
         rsp_code_in   = res_code;
         rsp_status_in = res_status;
      end else begin
         rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
         rsp_code_in   = rsp_code_ff;
         rsp_status_in = rsp_status_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff          <= PH_HEADER;
         byte_index_ff     <= '0;
         total_length_ff   <= '0;
         record_offset_ff  <= '0;
         skip_remaining_ff <= '0;
         part_length_ff    <= '0;
         part_count_ff     <= '0;
         sku_chars_ff      <= '0;
         header_ok_ff      <= 1'b1;
         rsp_valid_ff      <= 1'b0;
      end else begin
         phase_ff          <= phase_in;
         byte_index_ff     <= byte_index_in;
         total_length_ff   <= total_length_in;
         record_offset_ff  <= record_offset_in;
         skip_remaining_ff <= skip_remaining_in;
         part_length_ff    <= part_length_in;
         part_count_ff     <= part_count_in;
         sku_chars_ff      <= sku_chars_in;
         header_ok_ff      <= header_ok_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
      rsp_code_ff   <= rsp_code_in;
      rsp_status_ff <= rsp_status_in;
   end

endmodule
